>>> rtl/core/hmtri_pkg.sv
// ----------------------------------------------------------------------------
// hmtri_pkg
// Shared types, constants and triangle tables for the heightmap triangulator.
// ----------------------------------------------------------------------------
`default_nettype none

package hmtri_pkg;

  localparam int unsigned DIM_W   = 13;  // grid_width / grid_rows register width
  localparam int unsigned IDX_W   = 25;  // vertex index width
  localparam int unsigned POS_W   = 13;  // half-unit position width
  localparam int unsigned HQ_W    = 10;  // quarter-unit height width
  localparam int unsigned COORD_W = 16;  // grid coordinate carried in a job
  localparam int unsigned STEP_W  = 4;   // vertex step within one cell
  localparam int unsigned APB_AW  = 4;
  localparam int unsigned APB_DW  = 32;
  localparam int unsigned QDEPTH  = 2;
  localparam int unsigned QPTR_W  = 1;

  localparam logic [DIM_W-1:0] DIM_MIN     = 13'd2;
  localparam logic [DIM_W-1:0] WIDTH_RESET = 13'd2;
  localparam logic [DIM_W-1:0] ROWS_RESET  = 13'd2;
  localparam logic [1:0]       MODE_RESET  = 2'd0;
  localparam logic [IDX_W-1:0] CIDX_RESET  = 25'd4;

  typedef enum logic [1:0] {
    REG_GRID_WIDTH = 2'd0,
    REG_GRID_ROWS  = 2'd1,
    REG_SPLIT_MODE = 2'd2
  } reg_sel_t;

  typedef enum logic [1:0] {
    SPLIT_CENTER = 2'd0,
    SPLIT_SWNE   = 2'd1,
    SPLIT_SENW   = 2'd2
  } split_mode_t;

  typedef enum logic [2:0] {
    CORNER_SW  = 3'd0,
    CORNER_SE  = 3'd1,
    CORNER_NW  = 3'd2,
    CORNER_NE  = 3'd3,
    CORNER_CTR = 3'd4
  } corner_t;

  localparam corner_t TRI_CENTER [12] = '{
    CORNER_CTR, CORNER_SE, CORNER_SW,
    CORNER_CTR, CORNER_SW, CORNER_NW,
    CORNER_CTR, CORNER_NW, CORNER_NE,
    CORNER_CTR, CORNER_NE, CORNER_SE
  };
  localparam corner_t TRI_SWNE [6] = '{
    CORNER_SW, CORNER_NE, CORNER_SE,
    CORNER_SW, CORNER_NW, CORNER_NE
  };
  localparam corner_t TRI_SENW [6] = '{
    CORNER_SE, CORNER_SW, CORNER_NW,
    CORNER_SE, CORNER_NW, CORNER_NE
  };

  // Effective configuration seen by the datapath
  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] rows;
    logic [IDX_W-1:0] area;
    logic [1:0]       mode;
  } cfg_t;

  // One closed cell waiting for vertex emission
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] z;
    logic [DIM_W-1:0]   width;
    logic [IDX_W-1:0]   base;
    logic [IDX_W-1:0]   cidx;
    logic [7:0]         h_sw;
    logic [7:0]         h_se;
    logic [7:0]         h_nw;
    logic [7:0]         h_ne;
    logic [HQ_W-1:0]    h_sum;
    logic [1:0]         mode;
  } job_t;

  function automatic corner_t tri_corner(input logic [1:0] mode,
                                         input logic [STEP_W-1:0] step);
    corner_t c;
    c = CORNER_CTR;
    case (mode)
      SPLIT_CENTER: begin
        if (step < 4'd12) c = TRI_CENTER[step];
      end
      SPLIT_SWNE: begin
        if (step < 4'd6) c = TRI_SWNE[step[2:0]];
      end
      SPLIT_SENW: begin
        if (step < 4'd6) c = TRI_SENW[step[2:0]];
      end
      default: c = CORNER_CTR;
    endcase
    return c;
  endfunction

  function automatic logic [STEP_W-1:0] tri_count(input logic [1:0] mode);
    return (mode == SPLIT_CENTER) ? 4'd12 : 4'd6;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/hmtri_front.sv
// ----------------------------------------------------------------------------
// hmtri_front
// Accepts samples, tracks the raster position, keeps the previous row and
// turns every interior sample into a cell job for the emitter (none in split_mode 3).
// ----------------------------------------------------------------------------
`default_nettype none

module hmtri_front #(
  parameter int unsigned MAX_WIDTH = 4096,
  parameter int unsigned MAX_ROWS  = 4096
) (
  input  logic              clk,
  input  logic              rst,
  input  hmtri_pkg::cfg_t   cfg,
  input  logic              sample_valid,
  output logic              sample_ready,
  input  logic [7:0]        height_sample,
  output logic              job_push,
  output hmtri_pkg::job_t   job,
  input  logic              job_full
);
  import hmtri_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = $clog2(MAX_ROWS);

  logic [CW-1:0]      col_count;
  logic [RW-1:0]      row_count;
  logic [7:0]         upper_left;
  logic [7:0]         left_sample;
  logic [IDX_W-1:0]   center_index;

  logic [CW-1:0]      cur_x;
  logic [RW-1:0]      cur_z;
  logic [RW:0]        z_step;
  logic [CW:0]        x_inc;
  logic [RW:0]        z_inc;
  logic [CW-1:0]      col_next;
  logic [RW-1:0]      row_next;
  logic               accept;

  logic [7:0]         row_store [MAX_WIDTH];
  logic [7:0]         above;

  logic               s1_valid;
  logic [CW-1:0]      s1_x;
  logic [RW-1:0]      s1_z;
  logic [7:0]         s1_h;
  logic               s1_first;
  logic               s1_adv;
  logic               emit;
  logic               bump;
  logic [IDX_W-1:0]   cidx_cur;
  logic [IDX_W-1:0]   cidx_next;
  logic [RW-1:0]      z_prev;
  logic [RW+DIM_W-1:0] row_base_full;

  // Position of the incoming sample, and where the next one lands
  always_comb begin
    cur_x  = col_count;
    z_step = {1'b0, row_count};
    if (32'(col_count) >= 32'(cfg.width)) begin
      cur_x  = '0;
      z_step = z_step + 1'b1;
    end
    if (32'(z_step) >= 32'(cfg.rows)) begin
      cur_z = '0;
    end else begin
      cur_z = z_step[RW-1:0];
    end
    x_inc    = {1'b0, cur_x} + 1'b1;
    z_inc    = {1'b0, cur_z} + 1'b1;
    col_next = x_inc[CW-1:0];
    row_next = cur_z;
    if (32'(x_inc) >= 32'(cfg.width)) begin
      col_next = '0;
      if (32'(z_inc) >= 32'(cfg.rows)) begin
        row_next = '0;
      end else begin
        row_next = z_inc[RW-1:0];
      end
    end
  end

  assign accept       = sample_valid && sample_ready;
  assign sample_ready = !s1_valid || s1_adv;

  // Previous row: old value comes out, new sample goes in at the same column
  always_ff @(posedge clk) begin
    if (accept) begin
      above           <= row_store[cur_x];
      row_store[cur_x] <= height_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_x     <= cur_x;
      s1_z     <= cur_z;
      s1_h     <= height_sample;
      s1_first <= (cur_x == '0) && (cur_z == '0);
    end
  end

  always_comb begin
    emit = (s1_x != '0) && (s1_z != '0) &&
           ((cfg.mode == SPLIT_CENTER) || (cfg.mode == SPLIT_SWNE) ||
            (cfg.mode == SPLIT_SENW));
    bump      = emit && (cfg.mode == SPLIT_CENTER);
    cidx_cur  = s1_first ? cfg.area : center_index;
    cidx_next = cidx_cur + {{(IDX_W-1){1'b0}}, bump};
    s1_adv    = s1_valid && (!emit || !job_full);
    job_push  = s1_valid && emit && !job_full;
    z_prev    = s1_z - 1'b1;
    row_base_full = z_prev * cfg.width;
  end

  always_comb begin
    job.x     = COORD_W'(s1_x);
    job.z     = COORD_W'(s1_z);
    job.width = cfg.width;
    job.base  = IDX_W'(row_base_full);
    job.cidx  = cidx_cur;
    job.h_sw  = upper_left;
    job.h_se  = above;
    job.h_nw  = left_sample;
    job.h_ne  = s1_h;
    job.h_sum = HQ_W'(upper_left) + HQ_W'(above) + HQ_W'(left_sample) + HQ_W'(s1_h);
    job.mode  = cfg.mode;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      col_count    <= '0;
      row_count    <= '0;
      upper_left   <= '0;
      left_sample  <= '0;
      center_index <= CIDX_RESET;
    end else begin
      if (accept) begin
        col_count <= col_next;
        row_count <= row_next;
        s1_valid  <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        upper_left   <= above;
        left_sample  <= s1_h;
        center_index <= cidx_next;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/hmtri_queue.sv
// ----------------------------------------------------------------------------
// hmtri_queue
// Short job queue between the sample front end and the vertex emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module hmtri_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  hmtri_pkg::job_t push_data,
  output logic            full,
  input  logic            pop,
  output hmtri_pkg::job_t head,
  output logic            empty
);
  import hmtri_pkg::*;

  job_t               slots [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QPTR_W:0]    fill;

  assign full  = (fill == (QPTR_W+1)'(QDEPTH));
  assign empty = (fill == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/hmtri_back.sv
// ----------------------------------------------------------------------------
// hmtri_back
// Walks the triangle list of the job at the queue head and emits one vertex
// word per cycle, unless stalled by vertex_ready, through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module hmtri_back (
  input  logic                       clk,
  input  logic                       rst,
  input  hmtri_pkg::job_t            head,
  input  logic                       empty,
  output logic                       pop,
  output logic                       vertex_valid,
  input  logic                       vertex_ready,
  output logic [hmtri_pkg::IDX_W-1:0] vertex_index,
  output logic [hmtri_pkg::POS_W-1:0] pos_x_half,
  output logic [hmtri_pkg::POS_W-1:0] pos_z_half,
  output logic [hmtri_pkg::HQ_W-1:0]  height_quarter,
  output logic [1:0]                 tex_u_half,
  output logic [1:0]                 tex_v_half,
  output logic                       last_of_run
);
  import hmtri_pkg::*;

  logic [STEP_W-1:0]  step;
  corner_t            corner;
  logic               last;
  logic               load;
  logic               north;
  logic               west;
  logic [COORD_W-1:0] gx;
  logic [COORD_W-1:0] gz;
  logic [COORD_W-1:0] cx;
  logic [COORD_W-1:0] cz;
  logic [IDX_W-1:0]   row_idx;
  logic [IDX_W-1:0]   grid_idx;
  logic [7:0]         h_sel;

  logic [IDX_W-1:0]   v_idx;
  logic [POS_W-1:0]   v_px;
  logic [POS_W-1:0]   v_pz;
  logic [HQ_W-1:0]    v_hq;
  logic [1:0]         v_u;
  logic [1:0]         v_v;

  always_comb begin
    corner = tri_corner(head.mode, step);
    last   = (step == tri_count(head.mode) - 1'b1);
    load   = !empty && (!vertex_valid || vertex_ready);
    pop    = load && last;
  end

  always_comb begin
    north    = (corner == CORNER_NW) || (corner == CORNER_NE);
    west     = (corner == CORNER_SW) || (corner == CORNER_NW);
    gx       = head.x - {{(COORD_W-1){1'b0}}, west};
    gz       = head.z - {{(COORD_W-1){1'b0}}, !north};
    cx       = head.x - 1'b1;
    cz       = head.z - 1'b1;
    row_idx  = head.base + (north ? IDX_W'(head.width) : '0);
    grid_idx = row_idx + IDX_W'(gx);
    case (corner)
      CORNER_SW: h_sel = head.h_sw;
      CORNER_SE: h_sel = head.h_se;
      CORNER_NW: h_sel = head.h_nw;
      default:   h_sel = head.h_ne;
    endcase

    if (corner == CORNER_CTR) begin
      v_idx = head.cidx;
      v_px  = POS_W'({cx, 1'b1});
      v_pz  = POS_W'({cz, 1'b1});
      v_hq  = head.h_sum;
      v_u   = 2'd1;
      v_v   = 2'd1;
    end else begin
      v_idx = grid_idx;
      v_px  = POS_W'({gx, 1'b0});
      v_pz  = POS_W'({gz, 1'b0});
      v_hq  = {h_sel, 2'b00};
      v_u   = {grid_idx[0], 1'b0};
      v_v   = {gz[0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      vertex_index   <= v_idx;
      pos_x_half     <= v_px;
      pos_z_half     <= v_pz;
      height_quarter <= v_hq;
      tex_u_half     <= v_u;
      tex_v_half     <= v_v;
      last_of_run    <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_valid <= 1'b0;
      step         <= '0;
    end else begin
      if (load) begin
        vertex_valid <= 1'b1;
        step         <= last ? '0 : step + 1'b1;
      end else if (vertex_ready) begin
        vertex_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/heightmap_grid_triangulator.sv
// ----------------------------------------------------------------------------
// heightmap_grid_triangulator
// Raster heightmap samples in, triangle vertex words out.
// ----------------------------------------------------------------------------
// Samples on row 0 or column 0, and all samples while split_mode is 3, give
// no vertices. Every other sample closes one cell and gives 12 vertices
// (split_mode 0) or 6 (split_mode 1 or 2), emitted one word per cycle by the
// output stage while vertex_ready is high; that single vertex register is
// what limits a stream of interior samples. A two-entry cell queue lets the
// input keep taking samples while vertices drain. The first vertex of a cell
// passes the front-end stage register, the cell queue and the output
// register. The previous row lives in a MAX_WIDTH x 8 memory with one port.
// Program grid_width, grid_rows and split_mode at byte addresses 0, 4 and 8
// only while the block is idle.
`default_nettype none

module heightmap_grid_triangulator #(
  parameter int unsigned MAX_WIDTH = 4096,
  parameter int unsigned MAX_ROWS  = 4096
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [hmtri_pkg::APB_AW-1:0]      paddr,
  input  logic [hmtri_pkg::APB_DW-1:0]      pwdata,
  output logic [hmtri_pkg::APB_DW-1:0]      prdata,
  output logic                              pready,
  input  logic                              sample_valid,
  output logic                              sample_ready,
  input  logic [7:0]                        height_sample,
  output logic                              vertex_valid,
  input  logic                              vertex_ready,
  output logic [hmtri_pkg::IDX_W-1:0]       vertex_index,
  output logic [hmtri_pkg::POS_W-1:0]       pos_x_half,
  output logic [hmtri_pkg::POS_W-1:0]       pos_z_half,
  output logic [hmtri_pkg::HQ_W-1:0]        height_quarter,
  output logic [1:0]                        tex_u_half,
  output logic [1:0]                        tex_v_half,
  output logic                              last_of_run
);
  import hmtri_pkg::*;

  logic [DIM_W-1:0] grid_width;
  logic [DIM_W-1:0] grid_rows;
  logic [1:0]       split_mode;
  logic [DIM_W-1:0] w_eff;
  logic [DIM_W-1:0] h_eff;
  logic [IDX_W-1:0] area;
  logic             wr_en;
  cfg_t             cfg;

  logic             job_push;
  job_t             job;
  logic             job_full;
  logic             job_pop;
  job_t             job_head;
  logic             job_empty;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width <= WIDTH_RESET;
      grid_rows  <= ROWS_RESET;
      split_mode <= MODE_RESET;
    end else if (wr_en) begin
      unique case (reg_sel_t'(paddr[APB_AW-1:2]))
        REG_GRID_WIDTH: grid_width <= pwdata[DIM_W-1:0];
        REG_GRID_ROWS:  grid_rows  <= pwdata[DIM_W-1:0];
        REG_SPLIT_MODE: split_mode <= pwdata[1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel_t'(paddr[APB_AW-1:2]))
      REG_GRID_WIDTH: prdata = APB_DW'(grid_width);
      REG_GRID_ROWS:  prdata = APB_DW'(grid_rows);
      REG_SPLIT_MODE: prdata = APB_DW'(split_mode);
      default:        prdata = '0;
    endcase
  end

  // Clamp sizes into the supported range
  always_comb begin
    w_eff = grid_width;
    if (grid_width < DIM_MIN) begin
      w_eff = DIM_MIN;
    end else if (32'(grid_width) > MAX_WIDTH) begin
      w_eff = DIM_W'(MAX_WIDTH);
    end
    h_eff = grid_rows;
    if (grid_rows < DIM_MIN) begin
      h_eff = DIM_MIN;
    end else if (32'(grid_rows) > MAX_ROWS) begin
      h_eff = DIM_W'(MAX_ROWS);
    end
  end

  // First center index of a frame; read only while the frame's first sample sits in the front-end stage register
  always_ff @(posedge clk) begin
    area <= IDX_W'(w_eff) * IDX_W'(h_eff);
  end

  always_comb begin
    cfg.width = w_eff;
    cfg.rows  = h_eff;
    cfg.area  = area;
    cfg.mode  = split_mode;
  end

  hmtri_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_ROWS  (MAX_ROWS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .sample_valid  (sample_valid),
    .sample_ready  (sample_ready),
    .height_sample (height_sample),
    .job_push      (job_push),
    .job           (job),
    .job_full      (job_full)
  );

  hmtri_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (job_push),
    .push_data (job),
    .full      (job_full),
    .pop       (job_pop),
    .head      (job_head),
    .empty     (job_empty)
  );

  hmtri_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head           (job_head),
    .empty          (job_empty),
    .pop            (job_pop),
    .vertex_valid   (vertex_valid),
    .vertex_ready   (vertex_ready),
    .vertex_index   (vertex_index),
    .pos_x_half     (pos_x_half),
    .pos_z_half     (pos_z_half),
    .height_quarter (height_quarter),
    .tex_u_half     (tex_u_half),
    .tex_v_half     (tex_v_half),
    .last_of_run    (last_of_run)
  );

endmodule

`default_nettype wire

>>> rtl/core/hmtri_checker.sv
// ----------------------------------------------------------------------------
// hmtri_checker
// Port-level checks for the heightmap triangulator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module hmtri_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         vertex_valid,
  input logic                         vertex_ready,
  input logic [hmtri_pkg::IDX_W-1:0]  vertex_index,
  input logic [hmtri_pkg::POS_W-1:0]  pos_x_half,
  input logic [hmtri_pkg::POS_W-1:0]  pos_z_half,
  input logic [hmtri_pkg::HQ_W-1:0]   height_quarter,
  input logic [1:0]                   tex_u_half,
  input logic [1:0]                   tex_v_half,
  input logic                         last_of_run
);

  // Stalled vertex word holds its index and last flag
  a_vertex_hold: assert property (@(posedge clk) disable iff (rst)
    vertex_valid && !vertex_ready |=>
      vertex_valid && $stable(vertex_index) && $stable(last_of_run))
    else $error("vertex word changed while stalled");

  // Reset empties the output stage
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !vertex_valid)
    else $error("vertex valid after reset");

  // Center vertices carry half texture coordinates on both axes
  a_center_tex: assert property (@(posedge clk) disable iff (rst)
    vertex_valid |-> ((tex_u_half == 2'd1) == (tex_v_half == 2'd1)))
    else $error("mixed center and grid texture coordinates");

  // Grid vertices sit on even half-unit positions with whole-unit heights
  a_grid_align: assert property (@(posedge clk) disable iff (rst)
    vertex_valid && (tex_u_half != 2'd1) |->
      (height_quarter[1:0] == 2'b00) && !pos_x_half[0] && !pos_z_half[0])
    else $error("grid vertex off the grid");

endmodule

bind heightmap_grid_triangulator hmtri_checker u_hmtri_checker (.*);

`default_nettype wire
